// ===== rtl/core/sat_pkg.sv =====
package sat_pkg;

    localparam int CAPACITY = 16;
    localparam int DATA_W   = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_LOOKUP = 2'd1,
        MODE_REMOVE = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    // broadcast to every cell of the row
    typedef struct packed {
        logic              insert;
        logic              remove;
        logic [DATA_W-1:0] value;
        logic [IDX_W-1:0]  index;
        logic [CNT_W-1:0]  count;
    } t_cell_ctl;

endpackage

// ===== rtl/core/sat_cell.sv =====
module sat_cell (
    input  logic                      i_clk,
    input  sat_pkg::t_cell_ctl        i_ctl,
    input  logic [sat_pkg::IDX_W-1:0] i_pos,
    input  logic                      i_prev_ge,
    input  logic [sat_pkg::DATA_W-1:0] i_left_entry,
    input  logic [sat_pkg::DATA_W-1:0] i_right_entry,
    output logic                      o_ge,
    output logic [sat_pkg::DATA_W-1:0] o_entry
);
    import sat_pkg::*;

    logic [DATA_W-1:0] r_entry;
    logic [DATA_W-1:0] n_entry;
    logic              in_use;

    // a cell past the count, or holding a value not below the new one, yields
    assign in_use = {1'b0, i_pos} < i_ctl.count;
    assign o_ge   = !in_use || !(r_entry < i_ctl.value);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.insert && o_ge) begin
            n_entry = i_prev_ge ? i_left_entry : i_ctl.value;
        end else if (i_ctl.remove && (i_pos >= i_ctl.index)) begin
            n_entry = i_right_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

// ===== rtl/core/sorted_array_table.sv =====
// Sorted table of unsigned 32-bit entries held in a row of shifting cells.
// The result is registered and appears in the cycle after the item is accepted.
// Throughput: one item per cycle while the output is not stalled; every cell compares and shifts in parallel.
// Synchronous active-low reset clears the entry count and output valid;
// entry contents are not reset.
module sorted_array_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_mode,
    input  logic [31:0] i_value,
    input  logic [3:0]  i_index,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_read_data,
    output logic [1:0]  o_status,
    output logic [4:0]  o_count
);
    import sat_pkg::*;

    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic              r_out_valid;
    logic [DATA_W-1:0] r_read_data;
    logic [DATA_W-1:0] n_read_data;
    t_status           r_status;
    t_status           n_status;
    logic [CNT_W-1:0]  r_out_count;

    logic              accept;
    logic              idx_ok;
    t_cell_ctl         ctl;
    logic [DATA_W-1:0] entry [CAPACITY];
    logic              ge    [CAPACITY];

    assign o_stall = r_out_valid && i_stall;
    assign accept  = i_valid && !o_stall;
    assign idx_ok  = {1'b0, i_index} < r_count;

    always_comb begin
        ctl         = '0;
        ctl.value   = i_value;
        ctl.index   = i_index;
        ctl.count   = r_count;
        n_count     = r_count;
        n_read_data = '0;
        n_status    = ST_OK;
        unique case (t_mode'(i_mode))
            MODE_INSERT: begin
                if (r_count >= CNT_W'(CAPACITY)) begin
                    n_status = ST_FULL;
                end else begin
                    ctl.insert = accept;
                    n_count    = r_count + CNT_W'(1);
                end
            end
            MODE_LOOKUP: begin
                if (idx_ok) begin
                    n_read_data = entry[i_index];
                end else begin
                    n_status = ST_RANGE;
                end
            end
            MODE_REMOVE: begin
                if (idx_ok) begin
                    ctl.remove = accept;
                    n_count    = r_count - CNT_W'(1);
                end else begin
                    n_status = ST_RANGE;
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        logic              prev_ge;
        logic [DATA_W-1:0] left_entry;
        logic [DATA_W-1:0] right_entry;

        if (k == 0) begin : g_first
            assign prev_ge    = 1'b0;
            assign left_entry = '0;
        end else begin : g_mid
            assign prev_ge    = ge[k-1];
            assign left_entry = entry[k-1];
        end

        if (k == CAPACITY - 1) begin : g_last
            assign right_entry = '0;
        end else begin : g_inner
            assign right_entry = entry[k+1];
        end

        sat_cell u_cell (
            .i_clk         (i_clk),
            .i_ctl         (ctl),
            .i_pos         (IDX_W'(k)),
            .i_prev_ge     (prev_ge),
            .i_left_entry  (left_entry),
            .i_right_entry (right_entry),
            .o_ge          (ge[k]),
            .o_entry       (entry[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_read_data <= n_read_data;
            r_status    <= n_status;
            r_out_count <= n_count;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_read_data = r_read_data;
    assign o_status    = r_status;
    assign o_count     = r_out_count;

endmodule
